// ===== sv/unr_pkg.sv =====
// Shared types, widths and constants of the reciprocal divider.
// Holds the reciprocal seed table and the leading-zero count function.
// Depends on nothing; every other file imports it.
package unr_pkg;

  localparam int NUM_W  = 16;
  localparam int Z_W    = 4;
  localparam int N_W    = 31;
  localparam int IDX_W  = 9;
  localparam int SEED_W = 8;
  localparam int U_W    = 10;
  localparam int DU_W   = 26;
  localparam int E_W    = 18;
  localparam int EU_W   = 28;
  localparam int RCP_W  = 20;
  localparam int PROD_W = 51;
  localparam int QUOT_W = 17;

  localparam logic [QUOT_W-1:0] QUOT_MAX   = 17'h1FFFF;
  localparam logic [NUM_W-1:0]  IDX_ROUND  = 16'h0040;
  localparam logic [U_W-1:0]    SEED_BIAS  = 10'h101;
  localparam logic [DU_W-1:0]   NR_TWO     = 26'h2000080;
  localparam logic [EU_W-1:0]   RCP_ROUND  = 28'h0000080;
  localparam logic [PROD_W-1:0] QUOT_ROUND = 51'h8000;

  typedef struct packed {
    logic vld;
    logic ok;
  } ctl_t;

  localparam logic [SEED_W-1:0] SEED_ROM [0:256] = '{
    8'hff, 8'hfd, 8'hfb, 8'hf9, 8'hf7, 8'hf5, 8'hf3, 8'hf1,
    8'hef, 8'hee, 8'hec, 8'hea, 8'he8, 8'he6, 8'he4, 8'he3,
    8'he1, 8'hdf, 8'hdd, 8'hdc, 8'hda, 8'hd8, 8'hd6, 8'hd5,
    8'hd3, 8'hd1, 8'hd0, 8'hce, 8'hcd, 8'hcb, 8'hc9, 8'hc8,
    8'hc6, 8'hc5, 8'hc3, 8'hc1, 8'hc0, 8'hbe, 8'hbd, 8'hbb,
    8'hba, 8'hb8, 8'hb7, 8'hb5, 8'hb4, 8'hb2, 8'hb1, 8'hb0,
    8'hae, 8'had, 8'hab, 8'haa, 8'ha9, 8'ha7, 8'ha6, 8'ha4,
    8'ha3, 8'ha2, 8'ha0, 8'h9f, 8'h9e, 8'h9c, 8'h9b, 8'h9a,
    8'h99, 8'h97, 8'h96, 8'h95, 8'h94, 8'h92, 8'h91, 8'h90,
    8'h8f, 8'h8d, 8'h8c, 8'h8b, 8'h8a, 8'h89, 8'h87, 8'h86,
    8'h85, 8'h84, 8'h83, 8'h82, 8'h81, 8'h7f, 8'h7e, 8'h7d,
    8'h7c, 8'h7b, 8'h7a, 8'h79, 8'h78, 8'h77, 8'h75, 8'h74,
    8'h73, 8'h72, 8'h71, 8'h70, 8'h6f, 8'h6e, 8'h6d, 8'h6c,
    8'h6b, 8'h6a, 8'h69, 8'h68, 8'h67, 8'h66, 8'h65, 8'h64,
    8'h63, 8'h62, 8'h61, 8'h60, 8'h5f, 8'h5e, 8'h5d, 8'h5d,
    8'h5c, 8'h5b, 8'h5a, 8'h59, 8'h58, 8'h57, 8'h56, 8'h55,
    8'h54, 8'h53, 8'h53, 8'h52, 8'h51, 8'h50, 8'h4f, 8'h4e,
    8'h4d, 8'h4d, 8'h4c, 8'h4b, 8'h4a, 8'h49, 8'h48, 8'h48,
    8'h47, 8'h46, 8'h45, 8'h44, 8'h43, 8'h43, 8'h42, 8'h41,
    8'h40, 8'h3f, 8'h3f, 8'h3e, 8'h3d, 8'h3c, 8'h3c, 8'h3b,
    8'h3a, 8'h39, 8'h39, 8'h38, 8'h37, 8'h36, 8'h36, 8'h35,
    8'h34, 8'h33, 8'h33, 8'h32, 8'h31, 8'h31, 8'h30, 8'h2f,
    8'h2e, 8'h2e, 8'h2d, 8'h2c, 8'h2c, 8'h2b, 8'h2a, 8'h2a,
    8'h29, 8'h28, 8'h28, 8'h27, 8'h26, 8'h26, 8'h25, 8'h24,
    8'h24, 8'h23, 8'h22, 8'h22, 8'h21, 8'h20, 8'h20, 8'h1f,
    8'h1e, 8'h1e, 8'h1d, 8'h1d, 8'h1c, 8'h1b, 8'h1b, 8'h1a,
    8'h19, 8'h19, 8'h18, 8'h18, 8'h17, 8'h16, 8'h16, 8'h15,
    8'h15, 8'h14, 8'h14, 8'h13, 8'h12, 8'h12, 8'h11, 8'h11,
    8'h10, 8'h0f, 8'h0f, 8'h0e, 8'h0e, 8'h0d, 8'h0d, 8'h0c,
    8'h0c, 8'h0b, 8'h0a, 8'h0a, 8'h09, 8'h09, 8'h08, 8'h08,
    8'h07, 8'h07, 8'h06, 8'h06, 8'h05, 8'h05, 8'h04, 8'h04,
    8'h03, 8'h03, 8'h02, 8'h02, 8'h01, 8'h01, 8'h00, 8'h00,
    8'h00
  };

  function automatic logic [Z_W-1:0] lzc16(input logic [NUM_W-1:0] v);
    logic [Z_W-1:0] z;
    z = '0;
    for (int i = 0; i < NUM_W; i++) begin
      if (v[i]) begin
        z = Z_W'(NUM_W - 1 - i);
      end
    end
    return z;
  endfunction

endpackage

// ===== sv/unr_norm.sv =====
// Normalization front end: range check, leading-zero count, operand shift
// and reciprocal seed lookup, two register stages. Depends on unr_pkg.
module unr_norm (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [unr_pkg::NUM_W-1:0] num_i,
  input  logic [unr_pkg::NUM_W-1:0] den_i,
  output unr_pkg::ctl_t             ctl_o,
  output logic [unr_pkg::N_W-1:0]   n_o,
  output logic [unr_pkg::NUM_W-1:0] d_o,
  output logic [unr_pkg::U_W-1:0]   u_o
);
  import unr_pkg::*;

  ctl_t             ctl_a_r, ctl_a_nxt;
  logic [NUM_W-1:0] num_a_r;
  logic [NUM_W-1:0] den_a_r;
  logic [Z_W-1:0]   z_a_r, z_a_nxt;

  ctl_t             ctl_b_r;
  logic [N_W-1:0]   n_b_r, n_b_nxt;
  logic [NUM_W-1:0] d_b_r, d_b_nxt;
  logic [U_W-1:0]   u_b_r, u_b_nxt;
  logic [NUM_W-1:0] idx_sum;
  logic [IDX_W-1:0] idx;

  always_comb begin
    ctl_a_nxt.vld = vld_i;
    ctl_a_nxt.ok  = {den_i, 1'b0} > {1'b0, num_i};
    z_a_nxt       = lzc16(den_i);
  end

  always_comb begin
    n_b_nxt = N_W'(num_a_r) << z_a_r;
    d_b_nxt = den_a_r << z_a_r;
    idx_sum = {1'b0, d_b_nxt[NUM_W-2:0]} + IDX_ROUND;
    idx     = idx_sum[NUM_W-1:7];
    u_b_nxt = SEED_BIAS + U_W'(SEED_ROM[idx]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
      ctl_b_r <= '0;
    end else begin
      ctl_a_r <= ctl_a_nxt;
      ctl_b_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    num_a_r <= num_i;
    den_a_r <= den_i;
    z_a_r   <= z_a_nxt;
    n_b_r   <= n_b_nxt;
    d_b_r   <= d_b_nxt;
    u_b_r   <= u_b_nxt;
  end

  assign ctl_o = ctl_b_r;
  assign n_o   = n_b_r;
  assign d_o   = d_b_r;
  assign u_o   = u_b_r;

endmodule

// ===== sv/unr_recip.sv =====
// Newton-Raphson reciprocal refinement of the normalized divisor,
// two register stages, one multiplier each. Depends on unr_pkg.
module unr_recip (
  input  logic                      clk,
  input  logic                      rst_n,
  input  unr_pkg::ctl_t             ctl_i,
  input  logic [unr_pkg::N_W-1:0]   n_i,
  input  logic [unr_pkg::NUM_W-1:0] d_i,
  input  logic [unr_pkg::U_W-1:0]   u_i,
  output unr_pkg::ctl_t             ctl_o,
  output logic [unr_pkg::N_W-1:0]   n_o,
  output logic [unr_pkg::RCP_W-1:0] rcp_o
);
  import unr_pkg::*;

  ctl_t             ctl_c_r;
  logic [N_W-1:0]   n_c_r;
  logic [U_W-1:0]   u_c_r;
  logic [E_W-1:0]   e_c_r, e_c_nxt;
  logic [DU_W-1:0]  du;
  logic [DU_W-1:0]  err;

  ctl_t             ctl_d_r;
  logic [N_W-1:0]   n_d_r;
  logic [RCP_W-1:0] rcp_d_r, rcp_d_nxt;
  logic [EU_W-1:0]  eu;

  always_comb begin
    du      = DU_W'(d_i) * DU_W'(u_i);
    err     = NR_TWO - du;
    e_c_nxt = err[DU_W-1:8];
  end

  always_comb begin
    eu        = EU_W'(e_c_r) * EU_W'(u_c_r) + RCP_ROUND;
    rcp_d_nxt = eu[EU_W-1:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
      ctl_d_r <= '0;
    end else begin
      ctl_c_r <= ctl_i;
      ctl_d_r <= ctl_c_r;
    end
  end

  always_ff @(posedge clk) begin
    n_c_r   <= n_i;
    u_c_r   <= u_i;
    e_c_r   <= e_c_nxt;
    n_d_r   <= n_c_r;
    rcp_d_r <= rcp_d_nxt;
  end

  assign ctl_o = ctl_d_r;
  assign n_o   = n_d_r;
  assign rcp_o = rcp_d_r;

endmodule

// ===== sv/unr_mul.sv =====
// Quotient multiply, rounding and saturation, two register stages.
// Depends on unr_pkg.
module unr_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  unr_pkg::ctl_t              ctl_i,
  input  logic [unr_pkg::N_W-1:0]    n_i,
  input  logic [unr_pkg::RCP_W-1:0]  rcp_i,
  output logic                       vld_o,
  output logic [unr_pkg::QUOT_W-1:0] quot_o,
  output logic                       ovf_o
);
  import unr_pkg::*;

  ctl_t              ctl_e_r;
  logic [PROD_W-1:0] prod_e_r, prod_e_nxt;

  logic              vld_f_r;
  logic [QUOT_W-1:0] quot_f_r, quot_f_nxt;
  logic              ovf_f_r, ovf_f_nxt;
  logic [PROD_W-1:0] rnd;
  logic              sat;

  assign prod_e_nxt = PROD_W'(n_i) * PROD_W'(rcp_i);

  always_comb begin
    rnd = prod_e_r + QUOT_ROUND;
    sat = |rnd[PROD_W-1:QUOT_W+16];
    if (ctl_e_r.ok && !sat) begin
      quot_f_nxt = rnd[QUOT_W+15:16];
      ovf_f_nxt  = 1'b0;
    end else begin
      quot_f_nxt = QUOT_MAX;
      ovf_f_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
      vld_f_r <= 1'b0;
    end else begin
      ctl_e_r <= ctl_i;
      vld_f_r <= ctl_e_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_e_r <= prod_e_nxt;
    quot_f_r <= quot_f_nxt;
    ovf_f_r  <= ovf_f_nxt;
  end

  assign vld_o  = vld_f_r;
  assign quot_o = quot_f_r;
  assign ovf_o  = ovf_f_r;

endmodule

// ===== sv/unr_reciprocal_divider.sv =====
// Top level of the Newton-Raphson reciprocal divider.
// Depends on unr_pkg, unr_norm, unr_recip and unr_mul.
//
//   channel  ports                              handshake
//   input    in_dividend, in_divisor            start, busy
//   result   out_quotient, out_overflow         out_strobe
//
// One item per clock; busy is always low. Each taken item passes in order
// through two stages of normalization and seed lookup, two of reciprocal
// refinement, one for the quotient multiply and one for rounding and
// saturation. Synchronous reset clears all valid bits and drops items in
// flight. The receiver cannot stall, so nothing is held back.
module unr_reciprocal_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [unr_pkg::NUM_W-1:0]  in_dividend,
  input  logic [unr_pkg::NUM_W-1:0]  in_divisor,
  output logic                       out_strobe,
  output logic [unr_pkg::QUOT_W-1:0] out_quotient,
  output logic                       out_overflow
);
  import unr_pkg::*;

  ctl_t             ctl_norm;
  logic [N_W-1:0]   n_norm;
  logic [NUM_W-1:0] d_norm;
  logic [U_W-1:0]   u_norm;
  ctl_t             ctl_rcp;
  logic [N_W-1:0]   n_rcp;
  logic [RCP_W-1:0] rcp;
  logic             accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  unr_norm u_norm_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (accept),
    .num_i (in_dividend),
    .den_i (in_divisor),
    .ctl_o (ctl_norm),
    .n_o   (n_norm),
    .d_o   (d_norm),
    .u_o   (u_norm)
  );

  unr_recip u_recip_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_norm),
    .n_i   (n_norm),
    .d_i   (d_norm),
    .u_i   (u_norm),
    .ctl_o (ctl_rcp),
    .n_o   (n_rcp),
    .rcp_o (rcp)
  );

  unr_mul u_mul_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_rcp),
    .n_i    (n_rcp),
    .rcp_i  (rcp),
    .vld_o  (out_strobe),
    .quot_o (out_quotient),
    .ovf_o  (out_overflow)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("accepted item did not produce a result after six cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 6))
    else $error("result strobe without a matching accepted item");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_overflow |-> out_quotient == QUOT_MAX)
    else $error("overflow result not saturated");

  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && ($past(in_divisor, 6) == '0) |-> out_overflow)
    else $error("zero divisor did not flag overflow");

endmodule
